// File: rtl/rotated_rect_vertices_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotated rectangle vertex unit.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ROTATED_RECT_VERTICES_UNIT_ASSERT_SVH
`define ROTATED_RECT_VERTICES_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrv assertion failed");
`define RRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrv assertion failed");
`else
`define RRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/rrv_pkg.sv
// ----------------------------------------------------------------------------
// rrv_pkg
// Types, constants and the arctangent table of the rotated rectangle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rrv_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    // CORDIC gain 0.6072529350 in Q2.30.
    localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;

    localparam logic [1:0] VTX_BOTTOM_LEFT  = 2'd0;
    localparam logic [1:0] VTX_BOTTOM_RIGHT = 2'd1;
    localparam logic [1:0] VTX_TOP_RIGHT    = 2'd2;
    localparam logic [1:0] VTX_TOP_LEFT     = 2'd3;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]        rect_width;
        logic [30:0]        rect_height;
        logic [15:0]        turn_angle;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         vertex_index;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic               last_vertex;
    } out_item_t;

    // Centre in units of 2^-17 and the full size of the rectangle.
    typedef struct packed {
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic [30:0]        w;
        logic [30:0]        h;
    } geom_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
        geom_t              geom;
    } cordic_stage_t;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
        geom_t              geom;
    } trig_t;

    typedef struct packed {
        logic signed [63:0] wc;
        logic signed [63:0] ws;
        logic signed [63:0] hc;
        logic signed [63:0] hs;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
    } prod_t;

    // Arctangent of 2^-idx, with 2^32 units per turn.
    function automatic logic [31:0] atan_entry(input int unsigned idx);
        logic [31:0] val;
        unique case (idx)
            0:  val = 32'h20000000;
            1:  val = 32'h12E4051E;
            2:  val = 32'h09FB385B;
            3:  val = 32'h051111D4;
            4:  val = 32'h028B0D43;
            5:  val = 32'h0145D7E1;
            6:  val = 32'h00A2F61E;
            7:  val = 32'h00517C55;
            8:  val = 32'h0028BE53;
            9:  val = 32'h00145F2F;
            10: val = 32'h000A2F98;
            11: val = 32'h000517CC;
            12: val = 32'h00028BE6;
            13: val = 32'h000145F3;
            14: val = 32'h0000A2FA;
            15: val = 32'h0000517D;
            16: val = 32'h000028BE;
            17: val = 32'h0000145F;
            18: val = 32'h00000A30;
            19: val = 32'h00000518;
            20: val = 32'h0000028C;
            21: val = 32'h00000146;
            22: val = 32'h000000A3;
            23: val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rrv_cordic.sv
// ----------------------------------------------------------------------------
// rrv_cordic
// Pipelined CORDIC: one register stage per iteration, then a quadrant stage
// that yields cosine and sine. The rectangle geometry rides alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rrv_cordic #(
    parameter int CORDIC_STEPS = rrv_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rrv_pkg::in_item_t in_item,
    output logic                  trig_valid,
    input  wire logic             trig_ready,
    output rrv_pkg::trig_t        trig
);

    localparam int NSTG = (CORDIC_STEPS < rrv_pkg::ATAN_LEN) ?
                          CORDIC_STEPS : rrv_pkg::ATAN_LEN;

    rrv_pkg::cordic_stage_t stg_reg [0:NSTG];
    logic                   vld_reg [0:NSTG];
    logic                   adv     [0:NSTG];

    rrv_pkg::trig_t trig_reg;
    rrv_pkg::trig_t trig_next;
    logic           trig_vld_reg;
    logic           trig_adv;

    rrv_pkg::cordic_stage_t entry_next;

    // A stage takes new data when it is empty or its content moves on.
    assign trig_adv = !trig_vld_reg || trig_ready;
    assign adv[NSTG] = !vld_reg[NSTG] || trig_adv;

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_adv
            assign adv[k] = !vld_reg[k] || adv[k+1];
        end
    endgenerate

    assign in_ready = adv[0];

    always_comb
    begin
        entry_next.x         = rrv_pkg::CORDIC_GAIN;
        entry_next.y         = '0;
        entry_next.z         = $signed({2'b00, in_item.turn_angle[13:0], 16'h0000});
        entry_next.quad      = in_item.turn_angle[15:14];
        entry_next.geom.cx   = $signed({in_item.pos_x[31], in_item.pos_x, 1'b0})
                             + $signed({3'b000, in_item.rect_width});
        entry_next.geom.cy   = $signed({in_item.pos_y[31], in_item.pos_y, 1'b0})
                             + $signed({3'b000, in_item.rect_height});
        entry_next.geom.w    = in_item.rect_width;
        entry_next.geom.h    = in_item.rect_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv[0])
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            stg_reg[0] <= entry_next;
        end
    end

    generate
        for (k = 0; k < NSTG; k++) begin : g_iter
            localparam logic signed [31:0] ATAN_K = $signed(rrv_pkg::atan_entry(k));

            rrv_pkg::cordic_stage_t stg_next;
            logic signed [31:0]     xs;
            logic signed [31:0]     ys;

            always_comb
            begin
                xs       = stg_reg[k].x >>> k;
                ys       = stg_reg[k].y >>> k;
                stg_next = stg_reg[k];
                if (!stg_reg[k].z[31])
                begin
                    stg_next.x = stg_reg[k].x - ys;
                    stg_next.y = stg_reg[k].y + xs;
                    stg_next.z = stg_reg[k].z - ATAN_K;
                end
                else
                begin
                    stg_next.x = stg_reg[k].x + ys;
                    stg_next.y = stg_reg[k].y - xs;
                    stg_next.z = stg_reg[k].z + ATAN_K;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else if (adv[k+1])
                begin
                    vld_reg[k+1] <= vld_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[k+1] && vld_reg[k])
                begin
                    stg_reg[k+1] <= stg_next;
                end
            end
        end
    endgenerate

    // The upper two angle bits pick the quadrant; the turn is exact.
    always_comb
    begin
        trig_next.geom = stg_reg[NSTG].geom;
        unique case (stg_reg[NSTG].quad)
            2'd0:
            begin
                trig_next.c = stg_reg[NSTG].x;
                trig_next.s = stg_reg[NSTG].y;
            end
            2'd1:
            begin
                trig_next.c = -stg_reg[NSTG].y;
                trig_next.s = stg_reg[NSTG].x;
            end
            2'd2:
            begin
                trig_next.c = -stg_reg[NSTG].x;
                trig_next.s = -stg_reg[NSTG].y;
            end
            default:
            begin
                trig_next.c = stg_reg[NSTG].y;
                trig_next.s = -stg_reg[NSTG].x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_vld_reg <= 1'b0;
        end
        else if (trig_adv)
        begin
            trig_vld_reg <= vld_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (trig_adv && vld_reg[NSTG])
        begin
            trig_reg <= trig_next;
        end
    end

    assign trig_valid = trig_vld_reg;
    assign trig       = trig_reg;

endmodule

`default_nettype wire

// File: rtl/rrv_mult.sv
// ----------------------------------------------------------------------------
// rrv_mult
// Multiplier stage: width and height times cosine and sine. The four
// corners differ only in the signs of these products.
// ----------------------------------------------------------------------------
`default_nettype none

module rrv_mult (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           trig_valid,
    output logic                trig_ready,
    input  wire rrv_pkg::trig_t trig,
    output logic                prod_valid,
    input  wire logic           prod_ready,
    output rrv_pkg::prod_t      prod
);

    rrv_pkg::prod_t     prod_reg;
    rrv_pkg::prod_t     prod_next;
    logic               prod_vld_reg;
    logic               adv;
    logic signed [31:0] w_s;
    logic signed [31:0] h_s;

    assign adv        = !prod_vld_reg || prod_ready;
    assign trig_ready = adv;

    always_comb
    begin
        w_s          = $signed({1'b0, trig.geom.w});
        h_s          = $signed({1'b0, trig.geom.h});
        prod_next.wc = 64'(w_s) * 64'(trig.c);
        prod_next.ws = 64'(w_s) * 64'(trig.s);
        prod_next.hc = 64'(h_s) * 64'(trig.c);
        prod_next.hs = 64'(h_s) * 64'(trig.s);
        prod_next.cx = trig.geom.cx;
        prod_next.cy = trig.geom.cy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            prod_vld_reg <= trig_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && trig_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_vld_reg;
    assign prod       = prod_reg;

endmodule

`default_nettype wire

// File: rtl/rrv_vertex.sv
// ----------------------------------------------------------------------------
// rrv_vertex
// Holds one rectangle's products and walks its four corners, one a cycle when
// the output is not stalled: a rotation stage with rounding, then centre add,
// rounding and saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotated_rect_vertices_unit_assert.svh"

module rrv_vertex (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           prod_valid,
    output logic                prod_ready,
    input  wire rrv_pkg::prod_t prod,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rrv_pkg::out_item_t  out_item
);

    typedef struct packed {
        logic [1:0]         idx;
        logic               last;
        logic signed [35:0] rx;
        logic signed [35:0] ry;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
    } rot_t;

    localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;

    rrv_pkg::prod_t     hold_reg;
    logic               hold_vld_reg;
    logic [1:0]         k_reg;
    rot_t               rot_reg;
    rot_t               rot_next;
    logic               rot_vld_reg;
    rrv_pkg::out_item_t out_reg;
    rrv_pkg::out_item_t out_next;
    logic               out_vld_reg;

    logic               adv_out;
    logic               adv_rot;
    logic               step;
    logic               sx_neg;
    logic               sy_neg;
    logic signed [65:0] wc_e;
    logic signed [65:0] ws_e;
    logic signed [65:0] hc_e;
    logic signed [65:0] hs_e;
    logic signed [65:0] rx_sum;
    logic signed [65:0] ry_sum;
    logic signed [37:0] vx_sum;
    logic signed [37:0] vy_sum;
    logic [36:0]        vx;
    logic [36:0]        vy;

    assign adv_out    = !out_vld_reg || out_ready;
    assign adv_rot    = !rot_vld_reg || adv_out;
    assign step       = hold_vld_reg && adv_rot;
    assign prod_ready = !hold_vld_reg || (adv_rot && (k_reg == rrv_pkg::VTX_TOP_LEFT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            k_reg        <= rrv_pkg::VTX_BOTTOM_LEFT;
        end
        else
        begin
            if (prod_ready)
            begin
                hold_vld_reg <= prod_valid;
            end
            if (step)
            begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && prod_valid)
        begin
            hold_reg <= prod;
        end
    end

    // Left corners take -width, bottom corners take -height.
    always_comb
    begin
        sx_neg = (k_reg == rrv_pkg::VTX_BOTTOM_LEFT) || (k_reg == rrv_pkg::VTX_TOP_LEFT);
        sy_neg = (k_reg == rrv_pkg::VTX_BOTTOM_LEFT) || (k_reg == rrv_pkg::VTX_BOTTOM_RIGHT);
        wc_e   = 66'(hold_reg.wc);
        ws_e   = 66'(hold_reg.ws);
        hc_e   = 66'(hold_reg.hc);
        hs_e   = 66'(hold_reg.hs);
        rx_sum = (sx_neg ? -wc_e : wc_e) + (sy_neg ? hs_e : -hs_e) + ROUND_HALF;
        ry_sum = (sx_neg ? -ws_e : ws_e) + (sy_neg ? -hc_e : hc_e) + ROUND_HALF;
        rot_next.idx  = k_reg;
        rot_next.last = (k_reg == rrv_pkg::VTX_TOP_LEFT);
        rot_next.rx   = $signed(rx_sum[65:30]);
        rot_next.ry   = $signed(ry_sum[65:30]);
        rot_next.cx   = hold_reg.cx;
        rot_next.cy   = hold_reg.cy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_vld_reg <= 1'b0;
        end
        else if (adv_rot)
        begin
            rot_vld_reg <= hold_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rot_reg <= rot_next;
        end
    end

    // Round half up to Q16.16; saturate when the top bits disagree.
    always_comb
    begin
        vx_sum = 38'(rot_reg.cx) + 38'(rot_reg.rx) + 38'sd1;
        vy_sum = 38'(rot_reg.cy) + 38'(rot_reg.ry) + 38'sd1;
        vx     = vx_sum[37:1];
        vy     = vy_sum[37:1];
        out_next.vertex_index = rot_reg.idx;
        out_next.last_vertex  = rot_reg.last;
        if ((vx[36:31] == 6'h00) || (vx[36:31] == 6'h3F))
        begin
            out_next.vertex_x = $signed(vx[31:0]);
        end
        else
        begin
            out_next.vertex_x = vx[36] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        if ((vy[36:31] == 6'h00) || (vy[36:31] == 6'h3F))
        begin
            out_next.vertex_y = $signed(vy[31:0]);
        end
        else
        begin
            out_next.vertex_y = vy[36] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_vld_reg <= rot_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && rot_vld_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    `RRV_ASSERT_IMP(a_last_is_top_left, clk, rst_n, out_vld_reg && out_reg.last_vertex, out_reg.vertex_index == rrv_pkg::VTX_TOP_LEFT)
    `RRV_ASSERT_IMP(a_walk_needs_item, clk, rst_n, k_reg != rrv_pkg::VTX_BOTTOM_LEFT, hold_vld_reg)
    `RRV_ASSERT_IMP(a_take_only_at_end, clk, rst_n, hold_vld_reg && prod_ready, k_reg == rrv_pkg::VTX_TOP_LEFT)
    `RRV_ASSERT_NXT(a_walk_steps_once, clk, rst_n, step && (k_reg != rrv_pkg::VTX_TOP_LEFT), hold_vld_reg && (k_reg == $past(k_reg) + 2'd1))

endmodule

`default_nettype wire

// File: rtl/rotated_rect_vertices_unit.sv
// ----------------------------------------------------------------------------
// rotated_rect_vertices_unit
// Latency: the first vertex passes the CORDIC, product, hold, rotation and output
// registers; the rest follow when not stalled. Throughput: the corner walker
// takes a new item as its last corner steps and drives one vertex per cycle
// when not stalled onto the single output; an item enters in any cycle with room.
// Reset: rst_n clears all valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_rect_vertices_unit #(
    parameter int CORDIC_STEPS = rrv_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rrv_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rrv_pkg::out_item_t     out_item
);

    rrv_pkg::trig_t trig;
    logic           trig_valid;
    logic           trig_ready;
    rrv_pkg::prod_t prod;
    logic           prod_valid;
    logic           prod_ready;

    rrv_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .trig_valid (trig_valid),
        .trig_ready (trig_ready),
        .trig       (trig)
    );

    rrv_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .trig_valid (trig_valid),
        .trig_ready (trig_ready),
        .trig       (trig),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    rrv_vertex u_vertex (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

`default_nettype wire

// File: test/rrv_vertex_checker.sv
// ----------------------------------------------------------------------------
// Rotated rectangle vertex checker
// Watches both channels of the vertex unit. Each accepted rectangle is turned
// into its four expected corners by a CORDIC and fixed-point model of its
// own, and each accepted vertex is compared field by field with the oldest
// corner still waiting.
// ----------------------------------------------------------------------------
module rrv_vertex_checker #(
    parameter int CORDIC_STEPS = rrv_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  rrv_pkg::in_item_t  in_item,
    input  logic               out_valid,
    input  logic               out_ready,
    input  rrv_pkg::out_item_t out_item,
    output int                 mismatch_count,
    output int                 vertices_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     REPORT_LIMIT = 10;
    localparam int     TABLE_DEPTH  = 24;
    localparam longint HALF_Q30     = 64'sd536870912;
    localparam longint Q16_MAX      = 64'sd2147483647;
    localparam longint Q16_MIN      = -64'sd2147483648;

    // Arctangent of 2^-i, 2^32 units per turn.
    longint arctan_steps [0:TABLE_DEPTH-1] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    rrv_pkg::out_item_t expected_vertices [$];
    int                 errors = 0;

    initial
    begin
        mismatch_count   = 0;
        vertices_pending = 0;
    end

    // Cosine and sine in Q2.30. The CORDIC covers the first quadrant only and
    // the top two angle bits swap and negate its outputs exactly.
    function automatic void rotation_terms(input logic [15:0] angle,
                                           output longint cos_q30,
                                           output longint sin_q30);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = longint'(rrv_pkg::CORDIC_GAIN);
        y = 0;
        z = longint'(angle[13:0]) * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_DEPTH; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_steps[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_steps[i];
            end
        end
        case (angle[15:14])
            2'd0:
            begin
                cos_q30 = x;
                sin_q30 = y;
            end
            2'd1:
            begin
                cos_q30 = -y;
                sin_q30 = x;
            end
            2'd2:
            begin
                cos_q30 = -x;
                sin_q30 = -y;
            end
            default:
            begin
                cos_q30 = y;
                sin_q30 = -x;
            end
        endcase
    endfunction

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > Q16_MAX)
            return 32'sh7FFFFFFF;
        if (v < Q16_MIN)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Offsets and centre are kept in units of 2^-17 so that half sizes stay
    // exact; the final halving rounds half up.
    function automatic void push_corners(input rrv_pkg::in_item_t rect);
        longint             cos_q30;
        longint             sin_q30;
        longint             w;
        longint             h;
        longint             cx;
        longint             cy;
        longint             dx;
        longint             dy;
        longint             rx;
        longint             ry;
        logic [1:0]         corner;
        rrv_pkg::out_item_t v;
        rotation_terms(rect.turn_angle, cos_q30, sin_q30);
        w  = longint'(rect.rect_width);
        h  = longint'(rect.rect_height);
        cx = 2 * longint'($signed(rect.pos_x)) + w;
        cy = 2 * longint'($signed(rect.pos_y)) + h;
        for (int k = 0; k < 4; k++)
        begin
            corner = 2'(k);
            dx = (corner == rrv_pkg::VTX_BOTTOM_LEFT || corner == rrv_pkg::VTX_TOP_LEFT)
                 ? -w : w;
            dy = (corner == rrv_pkg::VTX_BOTTOM_LEFT || corner == rrv_pkg::VTX_BOTTOM_RIGHT)
                 ? -h : h;
            rx = (dx * cos_q30 - dy * sin_q30 + HALF_Q30) >>> 30;
            ry = (dx * sin_q30 + dy * cos_q30 + HALF_Q30) >>> 30;
            v.vertex_index = corner;
            v.vertex_x     = clamp_q16((cx + rx + 1) >>> 1);
            v.vertex_y     = clamp_q16((cy + ry + 1) >>> 1);
            v.last_vertex  = (corner == rrv_pkg::VTX_TOP_LEFT);
            expected_vertices.push_back(v);
        end
    endfunction

    always @(posedge clk)
    begin : scoreboard
        rrv_pkg::out_item_t want;
        if (rst_n)
        begin
            // Compare before predicting: a vertex leaving in this cycle can
            // never belong to the rectangle entering in the same cycle.
            if (out_valid && out_ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected vertex idx=%0d x=%h y=%h last=%0b",
                                 $realtime, out_item.vertex_index, out_item.vertex_x,
                                 out_item.vertex_y, out_item.last_vertex);
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (out_item.vertex_index !== want.vertex_index ||
                        out_item.vertex_x !== want.vertex_x ||
                        out_item.vertex_y !== want.vertex_y ||
                        out_item.last_vertex !== want.last_vertex)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: vertex mismatch exp idx=%0d x=%h y=%h last=%0b",
                                     $realtime, want.vertex_index, want.vertex_x,
                                     want.vertex_y, want.last_vertex,
                                     " got idx=%0d x=%h y=%h last=%0b",
                                     out_item.vertex_index, out_item.vertex_x,
                                     out_item.vertex_y, out_item.last_vertex);
                    end
                end
            end
            if (in_valid && in_ready)
                push_corners(in_item);
            mismatch_count   <= errors;
            vertices_pending <= expected_vertices.size();
        end
    end

endmodule

// File: test/rotated_rect_vertices_unit_tb.sv
// ----------------------------------------------------------------------------
// Rotated rectangle vertex unit testbench
// Drives directed corner cases and then random rectangles through the unit
// under several idle and stall patterns, with a pause for the pipeline to
// drain between phases. A separate checker predicts and compares vertices.
// ----------------------------------------------------------------------------
module rotated_rect_vertices_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT       = 4000;
    localparam int DRAIN_CYCLES     = rrv_pkg::CORDIC_STEPS_DEF + 10;
    localparam int RANDOM_PER_PHASE = 125;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    rrv_pkg::in_item_t  in_item   = '0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    rrv_pkg::out_item_t out_item;
    int                 mismatch_count;
    int                 vertices_pending;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 quiet_cycles   = 0;
    rrv_pkg::in_item_t  directed_rects [$];

    always #5 clk = ~clk;

    rotated_rect_vertices_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    rrv_vertex_checker vertex_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_item          (in_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_item         (out_item),
        .mismatch_count   (mismatch_count),
        .vertices_pending (vertices_pending)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic rrv_pkg::in_item_t make_rect(input logic [31:0] px,
                                                    input logic [31:0] py,
                                                    input logic [30:0] w,
                                                    input logic [30:0] h,
                                                    input logic [15:0] angle);
        rrv_pkg::in_item_t r;
        r.pos_x       = px;
        r.pos_y       = py;
        r.rect_width  = w;
        r.rect_height = h;
        r.turn_angle  = angle;
        return r;
    endfunction

    // Mostly moderate rectangles, some fully random, some pushed against the
    // coordinate limits so that saturation is exercised.
    function automatic rrv_pkg::in_item_t random_rect();
        rrv_pkg::in_item_t r;
        int unsigned       pick;
        pick = $urandom_range(9);
        if (pick < 5)
        begin
            r.pos_x       = $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
            r.pos_y       = $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
            r.rect_width  = 31'($urandom_range(32'h0100_0000));
            r.rect_height = 31'($urandom_range(32'h0100_0000));
        end
        else if (pick < 8)
        begin
            r.pos_x       = $urandom;
            r.pos_y       = $urandom;
            r.rect_width  = 31'($urandom);
            r.rect_height = 31'($urandom);
        end
        else
        begin
            r.pos_x       = {($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000, 16'($urandom)};
            r.pos_y       = {($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000, 16'($urandom)};
            r.rect_width  = {2'b11, 29'($urandom)};
            r.rect_height = {2'b11, 29'($urandom)};
        end
        if ($urandom_range(4) == 0)
            r.turn_angle = {2'($urandom), 14'h0} + 16'($urandom_range(2)) - 16'd1;
        else
            r.turn_angle = 16'($urandom);
        return r;
    endfunction

    // Valid stays high from one item to the next unless an idle gap is drawn.
    task automatic send_rect(input rrv_pkg::in_item_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // The pending count is updated at the edge, so it is read only once the edge has passed.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (vertices_pending != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_rect(random_rect());
        wait_drained();
    endtask

    initial
    begin
        directed_rects.push_back(make_rect(32'h0, 32'h0, 31'h0, 31'h0, 16'h0000));
        directed_rects.push_back(make_rect(32'h0, 32'h0, 31'h1, 31'h1, 16'h4000));
        directed_rects.push_back(make_rect(32'h0, 32'h0, 31'h10000, 31'h30000, 16'h8000));
        directed_rects.push_back(make_rect(32'h0, 32'h0, 31'h10000, 31'h30000, 16'hC000));
        directed_rects.push_back(make_rect(32'h50000, 32'h0, 31'h10000, 31'h20000, 16'h2000));
        directed_rects.push_back(make_rect(32'h10000, 32'h10000, 31'h40000, 31'h20000, 16'hFFFF));
        directed_rects.push_back(make_rect(32'h10000, 32'h10000, 31'h40000, 31'h20000, 16'h3FFF));
        directed_rects.push_back(make_rect(32'h0, 32'h0, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'h0000));
        // Corners far beyond the positive and negative coordinate limits.
        directed_rects.push_back(make_rect(32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                                           31'h7FFFFFFF, 16'h0000));
        directed_rects.push_back(make_rect(32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                                           31'h7FFFFFFF, 16'h8000));
        directed_rects.push_back(make_rect(32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF,
                                           31'h7FFFFFFF, 16'h2000));
        directed_rects.push_back(make_rect(32'h80000000, 32'h7FFFFFFF, 31'h0, 31'h0, 16'h0000));
        directed_rects.push_back(make_rect(32'h0, 32'h0, 31'h0, 31'h7FFFFFFF, 16'h4000));
        directed_rects.push_back(make_rect(32'h0, 32'h0, 31'h7FFFFFFF, 31'h0, 16'h6000));
        directed_rects.push_back(make_rect(32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF,
                                           31'h7FFFFFFF, 16'hFFFF));
        directed_rects.push_back(make_rect(32'h12345678, 32'h9ABCDEF0, 31'h00ABCDEF,
                                           31'h00123456, 16'h1234));
        directed_rects.push_back(make_rect(32'h0, 32'h0, 31'h100000, 31'h80000, 16'h0001));
        directed_rects.push_back(make_rect(32'h0, 32'h0, 31'h100000, 31'h80000, 16'h4001));
        directed_rects.push_back(make_rect(32'hFFFF0000, 32'h00010000, 31'h8000, 31'h18000,
                                           16'hBFFF));

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rects[i])
            send_rect(directed_rects[i]);
        wait_drained();

        run_phase(0, 0, RANDOM_PER_PHASE);
        run_phase(80, 0, RANDOM_PER_PHASE);
        run_phase(0, 80, RANDOM_PER_PHASE);
        run_phase(17, 17, RANDOM_PER_PHASE);

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && vertices_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
